@@ hw/rtl/brace_record_field_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the brace record field parser
// Concurrent checks on clk, disabled while arst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BRACE_RECORD_FIELD_PARSER_UNIT_ASSERT_SVH
`define BRACE_RECORD_FIELD_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BRFP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brfp: same-cycle check failed");

// Next-cycle implication
`define BRFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brfp: next-cycle check failed");

`else

`define BRFP_ASSERT_IMPL(lbl, ante, cons)
`define BRFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/brfp_pkg.sv @@
// ----------------------------------------------------------------------------
// brfp_pkg
// Types, constants and helpers shared by the brace record field parser.
// ----------------------------------------------------------------------------
package brfp_pkg;

	localparam logic [6:0] RECORD_LEN    = 7'd96;
	localparam logic [6:0] FIELD_END_POS = RECORD_LEN - 7'd3;
	localparam logic [6:0] LAST_FIELD_MAX = 7'd5;

	localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
	localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
	localparam logic [7:0] CH_COMMA = 8'h2C;  // ','

	localparam logic [2:0] FIELD_LAST = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEEK,
		PH_F0,
		PH_F1,
		PH_F2,
		PH_F3,
		PH_F4
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [6:0]  byte_position;
		logic [6:0]  field_char_count;
		logic [15:0] lookahead_window;  // older byte in the high half
		logic [1:0]  skip_count;
		logic        zero_seen;
	} brfp_state_t;

	typedef struct packed {
		logic       valid;
		logic       char_valid;
		logic [2:0] field_index;
		logic [7:0] char_value;
		logic       record_ok;
		logic       record_error;
		logic [6:0] error_position;
		logic [6:0] error_count;
	} brfp_result_t;

	function automatic logic [6:0] sat_add(input logic [6:0] v, input logic [1:0] d);
		logic [7:0] s;
		s = {1'b0, v} + {6'b0, d};
		return s[7] ? 7'h7F : s[6:0];
	endfunction

	function automatic logic [6:0] field_limit(input logic [1:0] f);
		logic [6:0] lim;
		unique case (f)
			2'd0:    lim = 7'd32;
			2'd1:    lim = 7'd64;
			2'd2:    lim = 7'd90;
			default: lim = 7'd15;
		endcase
		return lim;
	endfunction

endpackage

@@ hw/rtl/brfp_step.sv @@
// ----------------------------------------------------------------------------
// brfp_step
// Next-state and result logic for one record byte.
// ----------------------------------------------------------------------------
module brfp_step (
	input  brfp_pkg::brfp_state_t  state_in,
	input  logic [7:0]             data_byte,
	input  logic                   record_start,
	output brfp_pkg::brfp_state_t  state_out,
	output brfp_pkg::brfp_result_t res
);

	brfp_pkg::brfp_state_t cur;
	logic [6:0] pos1;
	logic [6:0] cnt1;
	logic [7:0] b0;
	logic [7:0] b1;
	logic [1:0] f;
	logic       zero_n;
	logic       done;

	function automatic brfp_pkg::phase_t phase_t_next(input brfp_pkg::phase_t p);
		return brfp_pkg::phase_t'(3'(p) + 3'd1);
	endfunction

	// a start byte restarts the record from a clean state
	always_comb begin
		if (record_start) begin
			cur = '0;
			cur.phase = brfp_pkg::PH_SEEK;
		end else begin
			cur = state_in;
		end
	end

	assign pos1 = brfp_pkg::sat_add(cur.byte_position, 2'd1);
	assign cnt1 = brfp_pkg::sat_add(cur.field_char_count, 2'd1);
	assign b0   = cur.lookahead_window[15:8];
	assign b1   = cur.lookahead_window[7:0];
	assign f    = 2'(3'(cur.phase) - 3'(brfp_pkg::PH_F0));

	always_comb begin
		state_out = cur;
		res       = '0;
		zero_n    = cur.zero_seen;
		done      = 1'b0;
		unique case (cur.phase)
			brfp_pkg::PH_IDLE: begin
				state_out = cur;
			end
			brfp_pkg::PH_SEEK: begin
				state_out.byte_position = pos1;
				if (data_byte == brfp_pkg::CH_OPEN) begin
					state_out.phase            = brfp_pkg::PH_F0;
					state_out.field_char_count = '0;
					state_out.lookahead_window = '0;
					state_out.skip_count       = '0;
					state_out.zero_seen        = 1'b0;
				end else if (pos1 >= brfp_pkg::RECORD_LEN) begin
					state_out.field_char_count = '0;
					state_out.phase            = brfp_pkg::PH_IDLE;
					res.valid          = 1'b1;
					res.record_error   = 1'b1;
					res.error_position = pos1;
				end
			end
			brfp_pkg::PH_F0, brfp_pkg::PH_F1, brfp_pkg::PH_F2, brfp_pkg::PH_F3: begin
				if (cur.skip_count < 2'd2) begin
					// filling the two-byte lookahead
					state_out.lookahead_window = {b1, data_byte};
					state_out.skip_count       = cur.skip_count + 2'd1;
				end else if (b0 == brfp_pkg::CH_CLOSE && b1 == brfp_pkg::CH_COMMA &&
						data_byte == brfp_pkg::CH_OPEN) begin
					state_out.byte_position    = brfp_pkg::sat_add(cur.byte_position, 2'd3);
					state_out.phase            = phase_t_next(cur.phase);
					state_out.field_char_count = '0;
					state_out.lookahead_window = '0;
					state_out.skip_count       = '0;
					state_out.zero_seen        = 1'b0;
				end else begin
					zero_n = cur.zero_seen | (b0 == 8'h00);
					state_out.zero_seen        = zero_n;
					state_out.byte_position    = pos1;
					state_out.field_char_count = cnt1;
					state_out.lookahead_window = {b1, data_byte};
					if (pos1 >= brfp_pkg::FIELD_END_POS || cnt1 >= brfp_pkg::field_limit(f)) begin
						state_out.phase    = brfp_pkg::PH_IDLE;
						res.valid          = 1'b1;
						res.record_error   = 1'b1;
						res.field_index    = {1'b0, f};
						res.error_position = pos1;
						res.error_count    = cnt1;
					end else if (!zero_n) begin
						res.valid       = 1'b1;
						res.char_valid  = 1'b1;
						res.field_index = {1'b0, f};
						res.char_value  = b0;
					end
				end
			end
			brfp_pkg::PH_F4: begin
				res.field_index = brfp_pkg::FIELD_LAST;
				if (data_byte == brfp_pkg::CH_CLOSE) begin
					state_out.phase = brfp_pkg::PH_IDLE;
					res.valid       = 1'b1;
					res.record_ok   = 1'b1;
				end else begin
					zero_n = cur.zero_seen | (data_byte == 8'h00);
					done   = (pos1 >= brfp_pkg::RECORD_LEN) || (cnt1 >= brfp_pkg::LAST_FIELD_MAX);
					state_out.zero_seen        = zero_n;
					state_out.byte_position    = pos1;
					state_out.field_char_count = cnt1;
					res.valid     = !zero_n || done;
					res.record_ok = done;
					if (!zero_n) begin
						res.char_valid = 1'b1;
						res.char_value = data_byte;
					end
					if (done) begin
						state_out.phase = brfp_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				state_out.phase = brfp_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/brace_record_field_parser_unit.sv @@
// ----------------------------------------------------------------------------
// brace_record_field_parser_unit
// Streaming parser for records of the form {f0},{f1},{f2},{f3},{f4}.
// ----------------------------------------------------------------------------
// One record byte is taken per clock, back to back, whenever the result
// register is empty or being drained in the same cycle. Each byte is judged
// by a single pass of compare and counter logic between the parser state
// registers and the result register, so a result appears on the master side
// in the cycle after the byte that caused it; bytes that cause no result (skipped
// bytes, lookahead fill, field separators, suppressed bytes after a zero)
// produce no transaction. In fields 0 to 3 a content byte is reported two
// bytes late, once its two lookahead bytes have arrived.
module brace_record_field_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] record_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] char_value, [14:8] error_position,
	                                    // [21:15] error_count, [23:22] zero
	output logic [5:0]  m_axis_tuser    // [0] char_valid, [3:1] field_index,
	                                    // [4] record_ok, [5] record_error
);

`include "brace_record_field_parser_unit_assert.svh"

	brfp_pkg::brfp_state_t  state_q;
	brfp_pkg::brfp_state_t  state_nxt;
	brfp_pkg::brfp_result_t step_res;
	brfp_pkg::brfp_result_t res_q;
	logic                   in_acc;
	logic                   ends_record;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	brfp_step u_step (
		.state_in     (state_q),
		.data_byte    (s_axis_tdata),
		.record_start (s_axis_tuser),
		.state_out    (state_nxt),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= state_nxt;
			end
			if (in_acc && step_res.valid) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc && step_res.valid) begin
			res_q <= step_res;
		end
	end

	assign m_axis_tdata = {2'b00, res_q.error_count, res_q.error_position, res_q.char_value};
	assign m_axis_tuser = {res_q.record_error, res_q.record_ok, res_q.field_index,
	                       res_q.char_valid};

	assign ends_record = in_acc && step_res.valid &&
	                     (step_res.record_error || step_res.record_ok);

	`BRFP_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
	`BRFP_ASSERT_IMPL(a_ok_not_err, m_axis_tvalid && res_q.record_ok, !res_q.record_error)
	`BRFP_ASSERT_IMPL(a_char_not_err, m_axis_tvalid && res_q.char_valid, !res_q.record_error)
	`BRFP_ASSERT_IMPL(a_ok_last_field, m_axis_tvalid && res_q.record_ok, res_q.field_index == brfp_pkg::FIELD_LAST)
	`BRFP_ASSERT_NEXT(a_error_goes_idle, ends_record, state_q.phase == brfp_pkg::PH_IDLE)

endmodule

@@ verif/tb_brace_record_field_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_brace_record_field_parser_unit
// Self-checking bench for the brace record field parser. A short opening
// script of bytes is followed by random records: well-formed ones with
// random field contents, truncated and mangled ones, seek overruns and
// noise. Every accepted byte runs through a local parser model and each
// output transaction is compared field by field with the oldest expected
// event. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_brace_record_field_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITEMS     = 850;
	localparam int TAIL_ITEMS  = 120;
	localparam int RX_HOLD     = 160;
	localparam int CYCLE_LIMIT = 600000;

	// count limits of fields 0..3, index 0 in the low bits
	localparam logic [3:0][6:0] FIELD_CAP = {7'd15, 7'd90, 7'd64, 7'd32};

	typedef struct packed {
		logic       char_valid;
		logic [2:0] field;
		logic [7:0] ch;
		logic       ok;
		logic       err;
		logic [6:0] epos;
		logic [6:0] ecnt;
	} field_event_t;

	typedef struct packed {
		brfp_pkg::phase_t ph;
		logic [6:0]       pos;
		logic [6:0]       cnt;
		logic [15:0]      win;   // older byte in the high half
		logic [1:0]       fill;
		logic             zero;
	} parse_state_t;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_GIVEN
	} chk_mode_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         start;
		chk_mode_t    mode;
		field_event_t ev;
	} script_row_t;

	localparam field_event_t NO_EVENT   = '0;
	localparam field_event_t REC_CLOSED = '{char_valid: 1'b0, field: brfp_pkg::FIELD_LAST,
		ch: 8'h00, ok: 1'b1, err: 1'b0, epos: 7'd0, ecnt: 7'd0};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [5:0]  m_axis_tuser;

	parse_state_t ps;
	field_event_t awaited_events[$];
	logic [8:0]   record_bytes[$];  // {start, data}
	int           busy_items;
	int           fail_count;
	int           cycle_count;
	bit           quiet_tail;
	bit           rx_hold_req;

	// opening script: stray byte, empty field, zero suppression, close on '}'
	script_row_t opening_script [25] = '{
		'{8'h41,              1'b0, CHK_NONE,    NO_EVENT},
		'{8'h78,              1'b1, CHK_NONE,    NO_EVENT},
		'{brfp_pkg::CH_OPEN,  1'b0, CHK_NONE,    NO_EVENT},
		'{8'hFF,              1'b0, CHK_PREDICT, NO_EVENT},
		'{8'h62,              1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_CLOSE, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_COMMA, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_OPEN,  1'b0, CHK_PREDICT, NO_EVENT},
		'{8'h00,              1'b0, CHK_PREDICT, NO_EVENT},
		'{8'h63,              1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_CLOSE, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_COMMA, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_OPEN,  1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_CLOSE, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_COMMA, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_OPEN,  1'b0, CHK_PREDICT, NO_EVENT},
		'{8'h64,              1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_CLOSE, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_COMMA, 1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_OPEN,  1'b0, CHK_PREDICT, NO_EVENT},
		'{8'h70,              1'b0, CHK_PREDICT, NO_EVENT},
		'{8'h71,              1'b0, CHK_PREDICT, NO_EVENT},
		'{brfp_pkg::CH_CLOSE, 1'b0, CHK_GIVEN,   REC_CLOSED},
		'{brfp_pkg::CH_CLOSE, 1'b0, CHK_NONE,    NO_EVENT},
		'{8'h80,              1'b1, CHK_NONE,    NO_EVENT}
	};

	brace_record_field_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [6:0] sat7(input logic [6:0] v, input int d);
		return (int'(v) + d > 127) ? 7'd127 : 7'(int'(v) + d);
	endfunction

	function automatic void open_field(input brfp_pkg::phase_t p);
		ps.ph   = p;
		ps.cnt  = '0;
		ps.win  = '0;
		ps.fill = '0;
		ps.zero = 1'b0;
	endfunction

	function automatic field_event_t error_event(input logic [2:0] f);
		field_event_t ev;
		ev      = '0;
		ev.field = f;
		ev.err  = 1'b1;
		ev.epos = ps.pos;
		ev.ecnt = ps.cnt;
		ps.ph   = brfp_pkg::PH_IDLE;
		return ev;
	endfunction

	// advances the parser model by one byte; returns 1 when an event is due
	function automatic bit parse_byte(input logic [7:0] b, input logic st,
			output field_event_t ev);
		logic [1:0] f;
		logic [7:0] older;
		logic       keep;
		ev = '0;
		if (st) begin
			ps    = '0;
			ps.ph = brfp_pkg::PH_SEEK;
		end
		case (ps.ph)
			brfp_pkg::PH_IDLE: return 1'b0;
			brfp_pkg::PH_SEEK: begin
				ps.pos = sat7(ps.pos, 1);
				if (b == brfp_pkg::CH_OPEN) begin
					open_field(brfp_pkg::PH_F0);
					return 1'b0;
				end
				if (ps.pos >= brfp_pkg::RECORD_LEN) begin
					ps.cnt = '0;
					ev = error_event(3'd0);
					return 1'b1;
				end
				return 1'b0;
			end
			brfp_pkg::PH_F4: begin
				ev.field = brfp_pkg::FIELD_LAST;
				if (b == brfp_pkg::CH_CLOSE) begin
					ev.ok = 1'b1;
					ps.ph = brfp_pkg::PH_IDLE;
					return 1'b1;
				end
				if (b == 8'h00)
					ps.zero = 1'b1;
				keep   = !ps.zero;
				ps.pos = sat7(ps.pos, 1);
				ps.cnt = sat7(ps.cnt, 1);
				if (keep) begin
					ev.char_valid = 1'b1;
					ev.ch         = b;
				end
				if (ps.pos >= brfp_pkg::RECORD_LEN || ps.cnt >= brfp_pkg::LAST_FIELD_MAX) begin
					ev.ok = 1'b1;
					ps.ph = brfp_pkg::PH_IDLE;
				end
				return keep || ev.ok;
			end
			default: begin
				// fields 0..3: judge the byte two places back
				f     = 2'(ps.ph - brfp_pkg::PH_F0);
				older = ps.win[15:8];
				if (ps.fill < 2'd2) begin
					ps.win  = {ps.win[7:0], b};
					ps.fill = ps.fill + 2'd1;
					return 1'b0;
				end
				if (older == brfp_pkg::CH_CLOSE && ps.win[7:0] == brfp_pkg::CH_COMMA &&
						b == brfp_pkg::CH_OPEN) begin
					ps.pos = sat7(ps.pos, 3);
					open_field(brfp_pkg::phase_t'(ps.ph + 3'd1));
					return 1'b0;
				end
				if (older == 8'h00)
					ps.zero = 1'b1;
				keep   = !ps.zero;
				ps.pos = sat7(ps.pos, 1);
				ps.cnt = sat7(ps.cnt, 1);
				ps.win = {ps.win[7:0], b};
				if (ps.pos >= brfp_pkg::FIELD_END_POS || ps.cnt >= FIELD_CAP[f]) begin
					ev = error_event({1'b0, f});
					return 1'b1;
				end
				if (!keep)
					return 1'b0;
				ev.char_valid = 1'b1;
				ev.field      = {1'b0, f};
				ev.ch         = older;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic st, input chk_mode_t mode,
			input field_event_t given);
		field_event_t ev;
		bit           due;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		busy_items++;
		due = parse_byte(b, st, ev);
		case (mode)
			CHK_PREDICT: if (due) awaited_events.push_back(ev);
			CHK_GIVEN:   awaited_events.push_back(given);
			default: ;
		endcase
	endtask

	task automatic sender_gap();
		s_axis_tvalid <= 1'b0;
		repeat ($urandom_range(1, 13)) @(posedge clk);
	endtask

	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_events.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] content_byte();
		case ($urandom_range(0, 39))
			0:       return 8'h00;
			1:       return brfp_pkg::CH_CLOSE;
			2:       return brfp_pkg::CH_COMMA;
			3:       return brfp_pkg::CH_OPEN;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic build_record();
		int         kind;
		int         len;
		int         cut;
		logic [7:0] b;
		record_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 4) begin
			// no opening brace within the seek window
			len = $urandom_range(96, 99);
			repeat (len) begin
				b = 8'($urandom);
				record_bytes.push_back({1'b0, (b == brfp_pkg::CH_OPEN) ? 8'h20 : b});
			end
			record_bytes[0][8] = 1'b1;
		end else if (kind >= 90) begin
			// noise, stray starts and all
			len = $urandom_range(1, 20);
			repeat (len)
				record_bytes.push_back({($urandom_range(0, 5) == 0), content_byte()});
		end else begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 95) : $urandom_range(0, 2);
			repeat (len) begin
				b = 8'($urandom);
				record_bytes.push_back({1'b0, (b == brfp_pkg::CH_OPEN) ? 8'h41 : b});
			end
			record_bytes.push_back({1'b0, brfp_pkg::CH_OPEN});
			for (int f = 0; f < 4; f++) begin
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(int'(FIELD_CAP[f]) - 2, int'(FIELD_CAP[f]) + 1);
				else
					len = $urandom_range(0, 6);
				repeat (len)
					record_bytes.push_back({1'b0, content_byte()});
				if (kind >= 70 && $urandom_range(0, 2) == 0) begin
					// mangled separator
					record_bytes.push_back({1'b0, brfp_pkg::CH_CLOSE});
					record_bytes.push_back({1'b0, content_byte()});
					record_bytes.push_back({1'b0, brfp_pkg::CH_OPEN});
				end else begin
					record_bytes.push_back({1'b0, brfp_pkg::CH_CLOSE});
					record_bytes.push_back({1'b0, brfp_pkg::CH_COMMA});
					record_bytes.push_back({1'b0, brfp_pkg::CH_OPEN});
				end
			end
			len = $urandom_range(0, 7);
			repeat (len)
				record_bytes.push_back({1'b0, content_byte()});
			if ($urandom_range(0, 1) == 0)
				record_bytes.push_back({1'b0, brfp_pkg::CH_CLOSE});
			record_bytes[0][8] = 1'b1;
			if (kind >= 60 && kind < 70) begin
				cut = $urandom_range(1, record_bytes.size());
				record_bytes = record_bytes[0:cut-1];
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		field_event_t got;
		field_event_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{char_valid: m_axis_tuser[0], field: m_axis_tuser[3:1],
				ch: m_axis_tdata[7:0], ok: m_axis_tuser[4], err: m_axis_tuser[5],
				epos: m_axis_tdata[14:8], ecnt: m_axis_tdata[21:15]};
			if (awaited_events.size() == 0) begin
				$error("unexpected transaction: tuser %h tdata %h", m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				want = awaited_events.pop_front();
				check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
				check_field("field_index", 8'(want.field), 8'(got.field));
				check_field("char_value", want.ch, got.ch);
				check_field("record_ok", 8'(want.ok), 8'(got.ok));
				check_field("record_error", 8'(want.err), 8'(got.err));
				check_field("error_position", 8'(want.epos), 8'(got.epos));
				check_field("error_count", 8'(want.ecnt), 8'(got.ecnt));
				check_field("tdata_pad", 8'h00, 8'(m_axis_tdata[23:22]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// master side: random ready, one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		repeat (10) @(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat (quiet_tail ? 1 : $urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		int rec_no;
		int idle_rate;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		ps            = '0;
		busy_items    = 0;
		fail_count    = 0;
		cycle_count   = 0;
		quiet_tail    = 1'b0;
		rx_hold_req   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (opening_script[i]) begin
			push_byte(opening_script[i].data, opening_script[i].start, opening_script[i].mode,
				opening_script[i].ev);
			if ($urandom_range(0, 4) == 0)
				sender_gap();
		end
		drain_pause();

		rec_no = 0;
		while (busy_items < N_ITEMS) begin
			build_record();
			idle_rate = $urandom_range(0, 3);
			if (rec_no == 3)
				rx_hold_req = 1'b1;
			foreach (record_bytes[i]) begin
				push_byte(record_bytes[i][7:0], record_bytes[i][8], CHK_PREDICT, NO_EVENT);
				if (!quiet_tail && idle_rate != 0 && $urandom_range(0, 7) < idle_rate)
					sender_gap();
			end
			if (!quiet_tail && rec_no % 9 == 5)
				drain_pause();
			if (busy_items >= N_ITEMS - TAIL_ITEMS)
				quiet_tail = 1'b1;
			rec_no++;
		end

		drain_pause();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/brfp_pkg.sv
hw/rtl/brfp_step.sv
hw/rtl/brace_record_field_parser_unit.sv
verif/tb_brace_record_field_parser_unit.sv
